// ===== sv/spfu_pkg.sv =====
// spfu_pkg: shared types, operation codes and constants for the binary32 unit.
// No dependencies.
`default_nettype none
package spfu_pkg;
  localparam logic [2:0] K_ADD = 3'd0;
  localparam logic [2:0] K_SUB = 3'd1;
  localparam logic [2:0] K_MUL = 3'd2;
  localparam logic [2:0] K_DIV = 3'd3;
  localparam logic [2:0] K_F2I = 3'd4;
  localparam logic [2:0] K_I2F = 3'd5;

  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic [31:0] INF  = 32'h7F800000;
  localparam logic [31:0] ILIM = 32'h4F000000;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
  } item_t;
endpackage
`default_nettype wire

// ===== sv/spfu_front.sv =====
// spfu_front: accepts items into a short queue in front of the datapath.
// Depends on spfu_pkg.
`default_nettype none
module spfu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire spfu_pkg::item_t  din,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output spfu_pkg::item_t       dout
);
  spfu_pkg::item_t mem_r [spfu_pkg::QDEPTH];
  logic [spfu_pkg::QAW-1:0] wp_r, rp_r;
  logic [spfu_pkg::QAW:0] cnt_r;

  assign full  = (cnt_r == 3'(spfu_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {2'b0, push} - {2'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(spfu_pkg::QDEPTH)) else $error("count out of range");
`endif
endmodule
`default_nettype wire

// ===== sv/spfu_back.sv =====
// spfu_back: computes one operation per item with an iterative divider.
// Depends on spfu_pkg.
`default_nettype none
module spfu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire spfu_pkg::item_t  it,
  output logic                  take,
  output logic                  res_vld,
  output logic [31:0]           res
);
  // Stage 1 registers a sum, product, conversion or special value, or launches the divider; stage 2 rounds.
  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;
  logic [1:0] st_r;
  logic [5:0] dcnt_r;
  logic [50:0] rem_r;
  logic [49:0] q_r;
  logic [23:0] dvs_r;

  logic        v1_r, sp1_r, sg1_r;
  logic [31:0] sv1_r;
  logic signed [11:0] e1_r;
  logic [49:0] sig1_r;

  function automatic logic [31:0] rpack(input logic sg, input logic signed [11:0] ei,
                                        input logic [49:0] si);
    logic [49:0] s;
    logic signed [11:0] e;
    logic [5:0] lz;
    logic [24:0] m;
    logic [9:0] be;
    logic [49:0] msk;
    int sh;
    s = si; e = ei; lz = '0;
    for (int i = 49; i >= 27; i--) if (s[i]) begin
      sh = i - 26; msk = (50'd1 << sh) - 1;
      s = (s >> sh) | {49'd0, |(si & msk)}; e = ei + 12'(sh); break;
    end
    if (s[49:26] == '0 || !s[26]) begin
      for (int i = 25; i >= 0; i--) if (s[i] && lz == 0) lz = 6'(26 - i);
      if (e - $signed({6'd0, lz}) < -12'sd126)
        lz = 6'(e + 12'sd126 > 0 ? e + 12'sd126 : 0);
      s = s << lz; e = e - 12'(lz);
    end
    if (e < -12'sd126) begin
      sh = int'(-12'sd126 - e);
      if (sh >= 49) s = {49'd0, |s};
      else begin msk = (50'd1 << sh) - 1; s = (s >> sh) | {49'd0, |(s & msk)}; end
      e = -12'sd126;
    end
    if (s[2:0] > 3'd4 || s[3:0] == 4'hC) s = s + 50'd4;
    m = s[27:3];
    if (m[24]) begin m = m >> 1; e = e + 12'sd1; end
    be = m[23] ? 10'(e + 12'sd127) : 10'd0;
    if ($signed({1'b0, be}) >= 255) return {sg, spfu_pkg::INF[30:0]};
    return {sg, be[7:0], m[22:0]};
  endfunction

  function automatic void unp(input logic [31:0] x, output logic [23:0] m,
                              output logic signed [11:0] e);
    logic [4:0] lz;
    lz = '0;
    if (x[30:23] == 0) begin
      for (int i = 22; i >= 0; i--) if (x[i] && lz == 0) lz = 5'(23 - i);
      m = {1'b0, x[22:0]} << lz; e = -12'sd126 - 12'(lz);
    end else begin
      m = {1'b1, x[22:0]}; e = 12'($signed({4'd0, x[30:23]})) - 12'sd127;
    end
  endfunction

  logic [31:0] a, b;
  logic an, bn, ai, bi, az, bz, sx;
  logic [23:0] ma, mb;
  logic signed [11:0] ea, eb;
  logic        c_sp, c_mul, c_div, c_add;
  logic [31:0] c_sv;
  logic signed [11:0] c_e;
  logic [49:0] c_sig;
  logic        c_sg;
  logic [26:0] xa, xb;
  logic [11:0] de;
  logic [31:0] mag;
  logic [7:0]  f_e;

  always_comb begin
    a = it.a;
    b = (it.kind == spfu_pkg::K_SUB) ? {~it.b[31], it.b[30:0]} : it.b;
    an = &a[30:23] && |a[22:0]; bn = &b[30:23] && |b[22:0];
    ai = &a[30:23] && !(|a[22:0]); bi = &b[30:23] && !(|b[22:0]);
    az = a[30:0] == 0; bz = b[30:0] == 0; sx = a[31] ^ b[31];
    unp(a, ma, ea); unp(b, mb, eb);
    c_sp = 1'b1; c_sv = '0; c_e = '0; c_sig = '0; c_sg = 1'b0;
    c_mul = 1'b0; c_div = 1'b0; c_add = 1'b0; xa = '0; xb = '0;
    de = '0; mag = '0; f_e = '0;
    case (it.kind)
      spfu_pkg::K_ADD, spfu_pkg::K_SUB: begin
        if (an || bn) c_sv = spfu_pkg::QNAN;
        else if (ai && bi) c_sv = (a[31] == b[31]) ? a : spfu_pkg::QNAN;
        else if (ai) c_sv = a;
        else if (bi) c_sv = b;
        else if (az && bz) c_sv = {a[31] & b[31], 31'd0};
        else if (az) c_sv = b;
        else if (bz) c_sv = a;
        else begin
          c_add = 1'b1;
          xa = {ma, 3'd0}; xb = {mb, 3'd0};
          if (ea < eb) begin
            de = 12'(eb - ea);
            xa = (de >= 27) ? 27'd1 : ((xa >> de) | {26'd0, |(xa & ((27'd1 << de) - 1))});
            c_e = eb;
          end else begin
            de = 12'(ea - eb);
            xb = (de >= 27) ? 27'd1 : ((xb >> de) | {26'd0, |(xb & ((27'd1 << de) - 1))});
            c_e = ea;
          end
        end
      end
      spfu_pkg::K_MUL: begin
        if (an || bn || (ai && bz) || (az && bi)) c_sv = spfu_pkg::QNAN;
        else if (ai || bi) c_sv = {sx, spfu_pkg::INF[30:0]};
        else if (az || bz) c_sv = {sx, 31'd0};
        else begin c_mul = 1'b1; c_e = ea + eb; c_sg = sx; end
      end
      spfu_pkg::K_DIV: begin
        if (an || bn || (ai && bi) || (az && bz)) c_sv = spfu_pkg::QNAN;
        else if (ai || bz) c_sv = {sx, spfu_pkg::INF[30:0]};
        else if (az || bi) c_sv = {sx, 31'd0};
        else begin c_div = 1'b1; c_e = ea - eb; c_sg = sx; end
      end
      spfu_pkg::K_F2I: begin
        f_e = a[30:23];
        if (an) c_sv = '0;
        else if (a[30:0] >= spfu_pkg::ILIM[30:0]) c_sv = a[31] ? 32'h80000000 : 32'h7FFFFFFF;
        else if (f_e < 8'd127) c_sv = '0;
        else begin
          mag = (f_e > 8'd150) ? ({8'd0, 1'b1, a[22:0]} << (f_e - 8'd150))
                               : ({8'd0, 1'b1, a[22:0]} >> (8'd150 - f_e));
          c_sv = a[31] ? (32'd0 - mag) : mag;
        end
      end
      spfu_pkg::K_I2F: begin
        if (it.a == 0) c_sv = '0;
        else begin
          c_sp = 1'b0; c_sg = it.a[31]; c_e = 12'sd26;
          c_sig = {18'd0, it.a[31] ? (32'd0 - it.a) : it.a};
        end
      end
      default: c_sv = '0;
    endcase
    if (c_mul || c_div || c_add) c_sp = 1'b0;
  end

  // Divider: restoring, one quotient bit per cycle, 50 bits.
  assign take = go && (st_r == S_RUN);

  logic [50:0] trial;
  assign trial = {rem_r[49:0], q_r[49]} - {27'd0, dvs_r};

  logic [47:0] prod;
  assign prod = {24'd0, ma} * {24'd0, mb};

  logic [49:0] add_sig;
  logic        add_sg;
  always_comb begin
    if (a[31] == b[31]) begin add_sig = {22'd0, {1'b0, xa} + {1'b0, xb}}; add_sg = a[31]; end
    else if (xa >= xb) begin add_sig = {23'd0, xa - xb}; add_sg = a[31]; end
    else begin add_sig = {23'd0, xb - xa}; add_sg = b[31]; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN; v1_r <= 1'b0;
    end else begin
      v1_r <= 1'b0;
      case (st_r)
        S_RUN: if (take) begin
          if (c_div) begin
            st_r <= S_DIV; dcnt_r <= 6'd50; rem_r <= '0;
            q_r <= {ma, 26'd0}; dvs_r <= mb;
            sg1_r <= c_sg; e1_r <= c_e;
          end else begin
            v1_r <= 1'b1; sp1_r <= c_sp; sv1_r <= c_sv; e1_r <= c_e;
            if (c_add) begin
              sg1_r <= add_sg;
              if (add_sig == 0) begin sp1_r <= 1'b1; sv1_r <= '0; end
              sig1_r <= add_sig;
            end else if (c_mul) begin
              sg1_r <= c_sg;
              sig1_r <= {22'd0, prod[47:20]} | {49'd0, |prod[19:0]};
            end else begin
              sg1_r <= c_sg; sig1_r <= c_sig;
            end
          end
        end
        S_DIV: begin
          if (!trial[50]) begin
            rem_r <= trial; q_r <= {q_r[48:0], 1'b1};
          end else begin
            rem_r <= {rem_r[49:0], q_r[49]}; q_r <= {q_r[48:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) st_r <= S_FIN;
        end
        S_FIN: begin
          st_r <= S_RUN; v1_r <= 1'b1; sp1_r <= 1'b0;
          sig1_r <= q_r | {49'd0, rem_r != 0};
        end
        default: st_r <= S_RUN;
      endcase
    end
  end

  logic        v2_r;
  logic [31:0] r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    r2_r <= sp1_r ? sv1_r : rpack(sg1_r, e1_r, sig1_r);
  end
  assign res_vld = v2_r;
  assign res = r2_r;

`ifndef SYNTH
  a_take_run: assert property (@(posedge clk) disable iff (!rst_n) take |-> st_r == S_RUN)
    else $error("accepted while dividing");
  a_vld_pipe: assert property (@(posedge clk) disable iff (!rst_n) v1_r |=> res_vld)
    else $error("lost result");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> dcnt_r != 0) else $error("divider count");
`endif
endmodule
`default_nettype wire

// ===== sv/single_precision_float_unit.sv =====
// single_precision_float_unit: top level, binary32 add/sub/mul/div/convert unit.
// Depends on spfu_pkg, spfu_front and spfu_back.
`default_nettype none
// Issue an item with start while busy is low; one beat comes back on out_valid
// and out_result_bits for one cycle, and the receiver cannot stall it. Add, sub,
// multiply and the conversions take one item per cycle while the back end is not
// dividing, passing through the queue, stage 1 and the result register; a divide
// holds the back end in its one-bit-per-cycle restoring divider, during which the
// four-entry queue keeps accepting until it fills and busy rises.
module single_precision_float_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  output logic [31:0]      out_result_bits
);
  spfu_pkg::item_t din, dq;
  logic full, empty, take, go;
  assign din = '{kind: in_kind, a: in_operand_a, b: in_operand_b};
  assign busy = full;
  assign go = !empty;

  spfu_front u_front (.clk, .rst_n, .push(start && !full), .din, .full,
                      .pop(take), .empty, .dout(dq));
  spfu_back u_back (.clk, .rst_n, .go, .it(dq), .take, .res_vld(out_valid),
                    .res(out_result_bits));
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for single_precision_float_unit: directed and random binary32
// operations are checked against a bit-exact behavioral predictor kept in a scoreboard class.
// Depends on spfu_pkg and the single_precision_float_unit RTL.
`default_nettype none
module testbench;

  // Behavioral predictor of the float unit. Values are carried as a significand with
  // three guard bits, the lowest of them sticky, exactly as the hardware is expected to round.
  class float_scoreboard;
    logic [31:0] pending_words[$];
    int unsigned mismatches;
    int unsigned checked;

    function automatic logic [63:0] shift_sticky(logic [63:0] v, int n);
      logic [63:0] mask;
      if (n <= 0) return v;
      if (n >= 63) return (v != 0) ? 64'd1 : 64'd0;
      mask = (64'd1 << n) - 64'd1;
      return (v >> n) | (((v & mask) != 0) ? 64'd1 : 64'd0);
    endfunction

    // Value is sig * 2^(e-26); rounds to nearest even and packs.
    function automatic logic [31:0] round_pack(logic sign, int e, logic [63:0] sig);
      logic [63:0] m;
      int be;
      while (sig >= (64'd1 << 27)) begin
        sig = shift_sticky(sig, 1);
        e++;
      end
      while (sig < (64'd1 << 26) && e > -126) begin
        sig = sig << 1;
        e--;
      end
      if (e < -126) begin
        sig = shift_sticky(sig, -126 - e);
        e = -126;
      end
      if ((sig[2:0] > 3'd4) || (sig[3:0] == 4'hC)) sig = sig + 64'd4;
      m = sig >> 3;
      if (m >= (64'd1 << 24)) begin
        m = m >> 1;
        e++;
      end
      be = (m < (64'd1 << 23)) ? 0 : e + 127;
      if (be >= 255) return {sign, 31'b0} | spfu_pkg::INF;
      return {sign, be[7:0], m[22:0]};
    endfunction

    function automatic bit is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction
    function automatic bit is_inf(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction
    function automatic bit is_zero(logic [31:0] x);
      return x[30:0] == 0;
    endfunction

    // Unpacks a finite nonzero operand and normalizes subnormals when norm is set.
    function automatic void split(logic [31:0] x, output logic [63:0] m, output int e,
                                  input bit norm);
      if (x[30:23] == 0) begin
        m = {41'b0, x[22:0]};
        e = -126;
      end else begin
        m = {40'b0, 1'b1, x[22:0]};
        e = int'(x[30:23]) - 127;
      end
      if (norm)
        while (m != 0 && m < (64'd1 << 23)) begin
          m = m << 1;
          e--;
        end
    endfunction

    function automatic logic [31:0] add_words(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, total;
      int ea, eb;
      logic sign;
      if (is_nan(a) || is_nan(b)) return spfu_pkg::QNAN;
      if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : spfu_pkg::QNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      split(a, ma, ea, 0);
      split(b, mb, eb, 0);
      ma = ma << 3;
      mb = mb << 3;
      if (ea < eb) begin
        ma = shift_sticky(ma, eb - ea);
        ea = eb;
      end else if (eb < ea) begin
        mb = shift_sticky(mb, ea - eb);
      end
      if (a[31] == b[31]) begin
        total = ma + mb;
        sign = a[31];
      end else if (ma >= mb) begin
        total = ma - mb;
        sign = a[31];
      end else begin
        total = mb - ma;
        sign = b[31];
      end
      if (total == 0) return 32'd0;
      return round_pack(sign, ea, total);
    endfunction

    function automatic logic [31:0] mul_words(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb;
      int ea, eb;
      logic sign;
      sign = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return spfu_pkg::QNAN;
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return spfu_pkg::QNAN;
      if (is_inf(a) || is_inf(b)) return {sign, 31'b0} | spfu_pkg::INF;
      if (is_zero(a) || is_zero(b)) return {sign, 31'b0};
      split(a, ma, ea, 1);
      split(b, mb, eb, 1);
      return round_pack(sign, ea + eb, shift_sticky(ma * mb, 20));
    endfunction

    function automatic logic [31:0] div_words(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, q, num;
      int ea, eb;
      logic sign;
      sign = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return spfu_pkg::QNAN;
      if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) return spfu_pkg::QNAN;
      if (is_inf(a) || is_zero(b)) return {sign, 31'b0} | spfu_pkg::INF;
      if (is_zero(a) || is_inf(b)) return {sign, 31'b0};
      split(a, ma, ea, 1);
      split(b, mb, eb, 1);
      num = ma << 26;
      q = num / mb;
      if (num % mb != 0) q[0] = 1'b1;
      return round_pack(sign, ea - eb, q);
    endfunction

    function automatic logic [31:0] float_to_int(logic [31:0] a);
      logic [31:0] m, v;
      int e;
      if (is_nan(a)) return 32'd0;
      if (a[30:0] >= spfu_pkg::ILIM[30:0]) return a[31] ? 32'h80000000 : 32'h7FFFFFFF;
      if (a[30:23] < 8'd127) return 32'd0;
      e = int'(a[30:23]) - 127;
      m = {9'b1, a[22:0]};
      v = (e > 23) ? (m << (e - 23)) : (m >> (23 - e));
      return a[31] ? -v : v;
    endfunction

    function automatic logic [31:0] int_to_float(logic [31:0] a);
      logic [31:0] mag;
      if (a == 0) return 32'd0;
      mag = a[31] ? -a : a;
      return round_pack(a[31], 26, {32'b0, mag});
    endfunction

    function void note_issue(logic [2:0] kind, logic [31:0] a, logic [31:0] b);
      logic [31:0] r;
      case (kind)
        spfu_pkg::K_ADD: r = add_words(a, b);
        spfu_pkg::K_SUB: r = add_words(a, b ^ 32'h80000000);
        spfu_pkg::K_MUL: r = mul_words(a, b);
        spfu_pkg::K_DIV: r = div_words(a, b);
        spfu_pkg::K_F2I: r = float_to_int(a);
        spfu_pkg::K_I2F: r = int_to_float(a);
        default: r = 32'd0;
      endcase
      pending_words.push_back(r);
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %h", got);
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result_bits expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_kind = spfu_pkg::K_ADD;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic [31:0] out_result_bits;

  float_scoreboard results_sb = new();
  int unsigned sender_idle_pct = 0;
  int unsigned idle_cycles = 0;
  int unsigned issued = 0;
  int unsigned leftover = 0;
  bit timed_out = 1'b0;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  single_precision_float_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result_bits(out_result_bits)
  );

  // Accepted beats are observed at the rising edge, before the driver's nonblocking
  // updates take effect, so the checker always sees the values the block sampled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) results_sb.note_issue(in_kind, in_operand_a, in_operand_b);
      if (out_valid) results_sb.check_result(out_result_bits);
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("ERROR: watchdog expired with %0d results pending",
                 results_sb.pending_words.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one operation and holds it until the block takes it. Random sender gaps
  // are inserted first, so start stays high across back-to-back beats.
  task automatic issue_op(logic [2:0] kind, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // Waits with the input quiet until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_sb.pending_words.size() != 0) @(posedge clk);
  endtask

  // Random operand biased toward interesting encodings: zeros, infinities, NaNs,
  // subnormals, extreme exponents and values near the int32 limits.
  function automatic logic [31:0] pick_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(11))
      0: r[30:0] = '0;
      1: r[30:0] = spfu_pkg::INF[30:0];
      2: r[30:23] = 8'hFF;
      3: r[30:23] = 8'h00;
      4: r[30:23] = 8'($urandom_range(1, 4));
      5: r[30:23] = 8'($urandom_range(250, 254));
      6: r[30:23] = 8'($urandom_range(150, 160));
      7: r[22:0] = $urandom_range(1) ? 23'h7FFFFF : 23'h000000;
      default: r[30:23] = 8'($urandom_range(100, 154));
    endcase
    return r;
  endfunction

  // Second operand is often made close to the first so that cancellation,
  // exact zero sums and ties in rounding are exercised.
  function automatic logic [31:0] pick_partner(logic [31:0] a);
    logic [31:0] b;
    case ($urandom_range(5))
      0: b = a ^ 32'h80000000;
      1: b = {~a[31], a[30:0] + 31'($urandom_range(3))};
      2: b = {$urandom_range(1) ? a[31] : ~a[31],
              a[30:23] - 8'($urandom_range(26)), 23'($urandom)};
      default: b = pick_operand();
    endcase
    return b;
  endfunction

  task automatic random_ops(int unsigned count);
    logic [2:0] kind;
    logic [31:0] a;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      // Divides are kept rarer since each one ties up the back end for a long time.
      pick = $urandom_range(9);
      kind = (pick > 7) ? spfu_pkg::K_ADD : 3'(pick);
      if (kind == spfu_pkg::K_DIV && $urandom_range(2) != 0) kind = spfu_pkg::K_MUL;
      a = pick_operand();
      if (kind == spfu_pkg::K_I2F && $urandom_range(1)) a = $urandom;
      issue_op(kind, a, pick_partner(a));
    end
  endtask

  initial begin
    int unsigned kinds_seen;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: every operation, plus NaN, infinity, zero, overflow,
    // underflow, saturation and unused operation codes.
    issue_op(spfu_pkg::K_ADD, 32'h00000000, 32'h80000000);
    issue_op(spfu_pkg::K_ADD, 32'h80000000, 32'h80000000);
    issue_op(spfu_pkg::K_ADD, 32'h3F800000, 32'hBF800000);
    issue_op(spfu_pkg::K_ADD, 32'h7F800000, 32'hFF800000);
    issue_op(spfu_pkg::K_SUB, 32'h7F7FFFFF, 32'hFF7FFFFF);
    issue_op(spfu_pkg::K_SUB, 32'h00000001, 32'h00000002);
    issue_op(spfu_pkg::K_ADD, 32'h7FC12345, 32'h3F800000);
    issue_op(spfu_pkg::K_MUL, 32'h7F800000, 32'h00000000);
    issue_op(spfu_pkg::K_MUL, 32'h80000001, 32'h3E800000);
    issue_op(spfu_pkg::K_MUL, 32'h7F7FFFFF, 32'h40000000);
    issue_op(spfu_pkg::K_MUL, 32'hFFFFFFFF, 32'h00000000);
    issue_op(spfu_pkg::K_DIV, 32'h00000000, 32'h80000000);
    issue_op(spfu_pkg::K_DIV, 32'hFF800000, 32'h7F800000);
    issue_op(spfu_pkg::K_DIV, 32'hBF800000, 32'h00000000);
    issue_op(spfu_pkg::K_DIV, 32'h3F800000, 32'h7F800000);
    issue_op(spfu_pkg::K_DIV, 32'h00000001, 32'h7F7FFFFF);
    issue_op(spfu_pkg::K_F2I, 32'h7F800000, 32'h0);
    issue_op(spfu_pkg::K_F2I, 32'hFF800000, 32'h0);
    issue_op(spfu_pkg::K_F2I, 32'hCF000000, 32'h0);
    issue_op(spfu_pkg::K_F2I, 32'hBF7FFFFF, 32'h0);
    issue_op(spfu_pkg::K_F2I, 32'hCEFFFFFF, 32'h0);
    issue_op(spfu_pkg::K_I2F, 32'h80000000, 32'h0);
    issue_op(spfu_pkg::K_I2F, 32'h7FFFFFFF, 32'h0);
    issue_op(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF);
    issue_op(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF);

    // The sender holds off here until the block has returned everything.
    drain();

    // Random phases with the sender's idling varied; the receiver cannot stall.
    sender_idle_pct = 0;
    random_ops(400);
    sender_idle_pct = 59;
    random_ops(380);
    drain();
    sender_idle_pct = 34;
    random_ops(380);
    sender_idle_pct = 0;
    random_ops(380);

    drain();
    repeat (80) @(posedge clk);
    leftover = results_sb.pending_words.size();
    kinds_seen = 8;
    $display("Run covered %0d issued operations over %0d operation codes,", issued, kinds_seen);
    $display("  %0d result beats checked with %0d mismatches and %0d left pending.",
             results_sb.checked, results_sb.mismatches, leftover);
    if (results_sb.mismatches == 0 && leftover == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/spfu_pkg.sv
sv/spfu_front.sv
sv/spfu_back.sv
sv/single_precision_float_unit.sv
tb/testbench.sv
